>>> hdl/bce_pkg.sv
// Package of types and constants for the binary cross-entropy block.
`timescale 1ns / 1ps
package bce_pkg;
    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic [16:0] predicted;
        logic [16:0] target;
        logic        last_element;
    } t_in;

    typedef struct packed {
        logic signed [33:0] gradient;
        logic [30:0]        loss_total;
        logic               loss_valid;
    } t_out;

    localparam logic [63:0] LN2_Q28 = 64'd186065279;
    localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;
    localparam logic [33:0] GRAD_LIMIT = 34'h1_0000_0000;
endpackage

>>> hdl/bce_neg_ln.sv
// Iterative -ln(x/S) unit: normalise, thirty squarings, scale by ln 2.
`timescale 1ns / 1ps
module bce_neg_ln #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS-1:0] i_x,
    output logic                 o_done,
    output logic [33:0]          o_result
);
    localparam int KW = $clog2(FRAC_BITS + 1);
    localparam logic [1:0] S_IDLE = 2'd0, S_NORM = 2'd1, S_SQ = 2'd2, S_MUL = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_m, n_m;
    logic [KW-1:0] r_k, n_k;
    logic [29:0] r_f, n_f;
    logic [4:0]  r_cnt, n_cnt;
    logic [33:0] r_res, n_res;
    logic        r_done, n_done;
    logic [63:0] w_sq;
    logic [31:0] w_sqm;
    logic [63:0] w_nl2;
    logic [63:0] w_prod;

    assign w_sq  = {32'd0, r_m} * {32'd0, r_m};
    assign w_sqm = w_sq[61:30];
    assign w_nl2 = ({{(64-KW){1'b0}}, r_k} << 30) - {34'd0, r_f};
    assign w_prod = w_nl2 * bce_pkg::LN2_Q28;

    always_comb begin
        n_state = r_state; n_m = r_m; n_k = r_k; n_f = r_f;
        n_cnt = r_cnt; n_res = r_res; n_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_m = {{(32-FRAC_BITS){1'b0}}, i_x};
                    n_k = '0; n_f = '0; n_cnt = '0;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_m[FRAC_BITS] == 1'b0) begin
                    n_m = r_m << 1;
                    n_k = r_k + 1'b1;
                end else begin
                    n_m = r_m << (30 - FRAC_BITS);
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (w_sqm[31]) begin
                    n_m = w_sqm >> 1;
                    n_f = {r_f[28:0], 1'b1};
                end else begin
                    n_m = w_sqm;
                    n_f = {r_f[28:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd29) n_state = S_MUL;
            end
            S_MUL: begin
                n_res = w_prod[61:28];
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
        end
        r_m <= n_m; r_k <= n_k; r_f <= n_f; r_cnt <= n_cnt; r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_result = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("done outside idle");
    a_norm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SQ |-> r_m[31] == 1'b0) else $error("mantissa overflow");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state) == S_MUL |-> r_done) else $error("missing done");
endmodule

>>> hdl/bce_divider.sv
// Restoring long divider for the gradient magnitude with rounding and saturation.
`timescale 1ns / 1ps
module bce_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [FRAC_BITS:0]     i_num,
    input  logic [2*FRAC_BITS:0]   i_den,
    output logic                   o_done,
    output logic [33:0]            o_mag
);
    localparam int NB = 3 * FRAC_BITS + 1;
    localparam int CW = $clog2(NB + 1);
    localparam int RW = 2 * FRAC_BITS + 2;

    logic          r_busy, r_done;
    logic [CW-1:0] r_i;
    logic [RW-1:0] r_rem;
    logic [34:0]   r_q;
    logic          r_sat;
    logic [FRAC_BITS:0]   r_num;
    logic [2*FRAC_BITS:0] r_den;
    logic [33:0]   w_mag;
    logic [RW-1:0] w_sh;
    logic          w_bit, w_ge;
    logic [RW-1:0] w_den;
    logic [CW-1:0] w_idx;
    logic [34:0]   w_q1;

    assign w_den = {1'b0, r_den};
    assign w_idx = r_i - CW'(2 * FRAC_BITS);
    assign w_bit = (r_i >= CW'(2 * FRAC_BITS)) ? r_num[w_idx[$clog2(FRAC_BITS+1)-1:0]] : 1'b0;
    assign w_sh  = {r_rem[RW-2:0], w_bit};
    assign w_ge  = w_sh >= w_den;
    assign w_q1  = r_q + 35'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_i <= CW'(NB - 1);
                r_rem <= '0; r_q <= '0; r_sat <= 1'b0;
                r_num <= i_num; r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sh - w_den : w_sh;
                if (r_q > 35'(bce_pkg::GRAD_LIMIT)) r_sat <= 1'b1;
                else r_q <= {r_q[33:0], w_ge};
                if (r_i == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else r_i <= r_i - 1'b1;
            end
        end
    end

    always_comb begin
        if (r_sat || r_q >= 35'(bce_pkg::GRAD_LIMIT)) w_mag = bce_pkg::GRAD_LIMIT;
        else if ({r_rem, 1'b0} >= {1'b0, w_den}) w_mag = w_q1[33:0];
        else w_mag = r_q[33:0];
    end

    assign o_done = r_done;
    assign o_mag = w_mag;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_mag_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> o_mag <= bce_pkg::GRAD_LIMIT) else $error("magnitude above limit");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_rem < w_den) else $error("remainder not reduced");
endmodule

>>> hdl/binary_cross_entropy_loss.sv
// Top level of the binary cross-entropy loss and gradient block.
//
//  Channel  Direction  Signals                     Payload
//  input    in         i_valid, o_stall, i_data    predicted, target, last_element
//  output   out        o_valid, i_stall, o_data    gradient, loss_total, loss_valid
//
// Without stalls, the time from one input transfer to the next is set by the
// 3*FRAC_BITS+1 divider steps, plus the start, collection, term and output steps.
// The two logarithms run alongside the divider.
// An endpoint element skips the divider and logarithms. Reset clears the loss sum.
// A new transfer is taken only after the previous result has left.
`timescale 1ns / 1ps
module binary_cross_entropy_loss (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bce_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output bce_pkg::t_out o_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_RUN = 3'd1, S_TERM = 3'd2, S_OUT = 3'd3;
    localparam logic [16:0] ONE = 17'h1_0000;

    logic [2:0]  r_state;
    logic [16:0] r_a, r_y;
    logic        r_last, r_end, r_neg;
    logic        r_la_ok, r_lb_ok, r_dv_ok;
    logic [33:0] r_la, r_lb;
    logic [33:0] r_mag;
    logic [63:0] r_acc;
    logic [30:0] r_sum;
    logic        r_start;
    logic [16:0] w_a, w_y;
    logic        la_done, lb_done, dv_done;
    logic [33:0] la_res, lb_res;
    logic [33:0] dv_mag;
    logic [16:0] w_num;
    logic [32:0] w_den;
    logic [63:0] w_p1, w_p2;
    logic [34:0] w_term;
    logic [31:0] w_sum;
    logic [30:0] w_sat;

    assign w_a = (i_data.predicted > ONE) ? ONE : i_data.predicted;
    assign w_y = (i_data.target > ONE) ? ONE : i_data.target;
    assign w_num = (r_a >= r_y) ? r_a - r_y : r_y - r_a;
    assign w_den = 33'({16'd0, r_a} * {16'd0, ONE - r_a});

    bce_neg_ln #(.FRAC_BITS(bce_pkg::FRAC_BITS)) u_ln_a (.i_clk, .i_rst_n,
        .i_start(r_start), .i_x(r_a[15:0]), .o_done(la_done), .o_result(la_res));
    bce_neg_ln #(.FRAC_BITS(bce_pkg::FRAC_BITS)) u_ln_b (.i_clk, .i_rst_n,
        .i_start(r_start), .i_x(16'(ONE - r_a)), .o_done(lb_done), .o_result(lb_res));
    bce_divider #(.FRAC_BITS(bce_pkg::FRAC_BITS)) u_div (.i_clk, .i_rst_n,
        .i_start(r_start), .i_num(w_num), .i_den(w_den), .o_done(dv_done),
        .o_mag(dv_mag));

    assign w_p1 = {47'd0, r_y} * {30'd0, r_la};
    assign w_p2 = {47'd0, 17'(ONE - r_y)} * {30'd0, r_lb};
    assign w_term = r_end ? 35'd0 : 35'((r_acc + 64'h2000_0000) >> 30);
    assign w_sum = {1'b0, r_sum} + ((w_term > 35'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_term[31:0]);
    assign w_sat = (w_sum > {1'b0, bce_pkg::ACC_MAX}) ? bce_pkg::ACC_MAX : w_sum[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum <= '0;
            r_start <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a <= w_a; r_y <= w_y; r_last <= i_data.last_element;
                        r_end <= (w_a == '0) || (w_a == ONE);
                        r_la_ok <= 1'b0; r_lb_ok <= 1'b0; r_dv_ok <= 1'b0;
                        r_acc <= '0; r_mag <= '0;
                        r_start <= !((w_a == '0) || (w_a == ONE));
                        r_state <= ((w_a == '0) || (w_a == ONE)) ? S_TERM : S_RUN;
                    end
                end
                S_RUN: begin
                    r_neg <= r_y > r_a;
                    if (la_done) begin r_la_ok <= 1'b1; r_la <= la_res; end
                    if (lb_done) begin r_lb_ok <= 1'b1; r_lb <= lb_res; end
                    if (dv_done) begin r_dv_ok <= 1'b1; r_mag <= dv_mag; end
                    if (r_la_ok && r_lb_ok && r_dv_ok) begin
                        r_acc <= w_p1 + w_p2;
                        r_state <= S_TERM;
                    end
                end
                S_TERM: begin
                    o_data.gradient <= r_neg && !r_end ? -$signed(r_mag) : $signed(r_mag);
                    o_data.loss_valid <= r_last;
                    o_data.loss_total <= r_last ? w_sat : '0;
                    r_sum <= r_last ? '0 : w_sat;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open while result pending");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == S_OUT) else $error("result outside output state");
    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TERM && r_last) |=> r_sum == '0) else $error("sum not cleared");
endmodule
